// ===== src/tmkd_pkg.sv =====
// Package for the trimmed-mean Kalman distance filter.
// Holds the configuration and command types shared by all modules.
// Depends on nothing.
`default_nettype none

package tmkd_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [2:0] REG_PROCESS_NOISE = 3'd1;
    localparam logic [2:0] REG_MEASURE_NOISE = 3'd2;
    localparam logic [2:0] REG_QUAD_COEFF    = 3'd3;
    localparam logic [2:0] REG_LIN_GAIN      = 3'd4;
    localparam logic [2:0] REG_CAL_OFFSET    = 3'd5;

    // Fixed widths of the filter arithmetic.
    localparam int VAR_W  = 18;
    localparam int PMID_W = 19;
    localparam int DEN_W  = 20;
    localparam int GAIN_W = 17;
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    typedef struct packed {
        logic        [6:0]  window_length;
        logic        [15:0] process_noise;
        logic        [15:0] measure_noise;
        logic signed [23:0] quad_coeff;
        logic signed [31:0] lin_gain;
        logic signed [39:0] cal_offset;
    } cfg_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MEAN_INIT,
        OP_DIV_STEP,
        OP_MEAN_DONE,
        OP_PMID,
        OP_K_INIT,
        OP_K_DONE,
        OP_MUL_XI,
        OP_MUL_MK,
        OP_EST,
        OP_VAR,
        OP_TSQ,
        OP_QLO,
        OP_QHI,
        OP_LIN,
        OP_CAL
    } dp_op_t;

    typedef struct packed {
        logic   sample_en;
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic close;
        logic primed;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/trimmed_mean_kalman_distance.sv =====
// Top level of the trimmed-mean Kalman distance filter: configuration
// registers, output register, controller and datapath.
// Depends on tmkd_pkg, tmkd_ctrl and tmkd_dp.
//
// Usage:
// Raw samples enter on the s_axis stream, one 16-bit reading per item.
// Each window of window_length samples (clamped to 3..MAX_WINDOW) is
// reduced to its mean without the largest and smallest sample, which feeds
// a scalar Kalman filter and a quadratic calibration. The first window only
// seeds the filter; every later window yields one item on m_axis.
// A sample that does not close a window is taken while the controller idles.
// The closing sample starts a sequence set by the bit-serial divider, which
// runs twice (mean and gain), and the shared multiplier steps; no sample is
// taken meanwhile (the first window stops after the mean). The result goes to
// m_axis when the sequence ends and the output register is free; the next
// sample follows once the result is loaded.
// A held result sits in the output register while samples keep flowing;
// only the next window's result waits for it to be taken.
// Reset clears the window, the filter state and the registers to defaults.
// Configuration is written on cfg_*, which is always ready.
`default_nettype none

module trimmed_mean_kalman_distance #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_axis_tdata: [15:0] sample_value
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    // m_axis_tdata: [31:0] trimmed_mean, [63:32] filtered_value, [79:64] distance
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [39:0] cfg_data
);
    import tmkd_pkg::*;

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [31:0] trimmed_mean;
    logic [31:0] filtered_value;
    logic [15:0] distance;
    logic        out_valid_reg;
    logic [79:0] out_data_reg;
    logic        out_free;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length <= 7'd50;
            cfg_reg.process_noise <= 16'd590;
            cfg_reg.measure_noise <= 16'd11796;
            cfg_reg.quad_coeff    <= 24'sd0;
            cfg_reg.lin_gain      <= 32'sd3291814;
            cfg_reg.cal_offset    <= -40'sd159140916;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WINDOW_LENGTH: cfg_reg.window_length <= cfg_data[6:0];
                REG_PROCESS_NOISE: cfg_reg.process_noise <= cfg_data[15:0];
                REG_MEASURE_NOISE: cfg_reg.measure_noise <= cfg_data[15:0];
                REG_QUAD_COEFF:    cfg_reg.quad_coeff    <= $signed(cfg_data[23:0]);
                REG_LIN_GAIN:      cfg_reg.lin_gain      <= $signed(cfg_data[31:0]);
                REG_CAL_OFFSET:    cfg_reg.cal_offset    <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    // Output register.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
            out_data_reg <= {distance, filtered_value, trimmed_mean};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    tmkd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    tmkd_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sample_value   (s_axis_tdata),
        .status         (status),
        .trimmed_mean   (trimmed_mean),
        .filtered_value (filtered_value),
        .distance       (distance)
    );

`ifndef SYNTHESIS
    // Samples are taken only while no result is being computed.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sample_en |-> s_axis_tready)
        else $error("sample taken while busy");

    // A loaded result shows up on the output the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

    // A stalled result is held.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result not held");
`endif

endmodule

`default_nettype wire

// ===== src/tmkd_dp.sv =====
// Datapath of the trimmed-mean Kalman distance filter: window statistics,
// a shared restoring divider and a shared multiplier with its accumulator.
// Depends on tmkd_pkg.
`default_nettype none

module tmkd_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tmkd_pkg::cfg_t       cfg,
    input  wire tmkd_pkg::dp_cmd_t    cmd,
    input  wire logic [15:0]          sample_value,
    output tmkd_pkg::dp_status_t      status,
    output logic [31:0]               trimmed_mean,
    output logic [31:0]               filtered_value,
    output logic [15:0]               distance
);
    import tmkd_pkg::*;

    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int SUMW = 16 + CW;
    localparam int NW   = (SUMW + 16 > PMID_W + 16) ? SUMW + 16 : PMID_W + 16;
    localparam int NCW  = $clog2(NW + 1);
    localparam int LW   = (CW > 7) ? CW : 7;
    localparam int RW   = DEN_W + 1;

    logic [CW-1:0]        count_reg;
    logic [SUMW-1:0]      sum_reg;
    logic [15:0]          max_reg;
    logic [15:0]          min_reg;
    logic                 primed_reg;
    logic [31:0]          mean_reg;
    logic [31:0]          est_reg;
    logic [VAR_W-1:0]     var_reg;
    logic [PMID_W-1:0]    pmid_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [GAIN_W-1:0]    k_reg;
    logic [GAIN_W-1:0]    inv_reg;
    logic [NW-1:0]        num_reg;
    logic [RW-1:0]        rem_reg;
    logic [DEN_W-1:0]     dvs_reg;
    logic [31:0]          quo_reg;
    logic [NCW-1:0]       dcnt_reg;
    logic signed [65:0]   prod_reg;
    logic signed [67:0]   acc_reg;
    logic [39:0]          tsq_reg;
    logic [15:0]          dist_reg;

    // Effective window length, clamped to 3..MAX_WINDOW.
    logic [CW-1:0] eff_len;
    always_comb
    begin
        if (cfg.window_length < 7'd3)
            eff_len = CW'(3);
        else if (LW'(cfg.window_length) > LW'(MAX_WINDOW))
            eff_len = CW'(MAX_WINDOW);
        else
            eff_len = CW'(cfg.window_length);
    end

    logic [CW:0] count_inc;
    assign count_inc = {1'b0, count_reg} + 1'b1;

    assign status.close    = (count_inc >= {1'b0, eff_len});
    assign status.primed   = primed_reg;
    assign status.div_last = (dcnt_reg == NCW'(1));

    // Divider trial subtraction.
    logic [RW-1:0] trial;
    logic          trial_ge;
    assign trial    = {rem_reg[RW-2:0], num_reg[NW-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    // Multiplier operand selection.
    logic signed [32:0] opa;
    logic signed [32:0] opb;
    always_comb
    begin
        opa = '0;
        opb = '0;
        case (cmd.op)
            OP_MUL_XI:
            begin
                opa = $signed({1'b0, est_reg});
                opb = $signed({16'b0, inv_reg});
            end
            OP_MUL_MK:
            begin
                opa = $signed({1'b0, mean_reg});
                opb = $signed({16'b0, k_reg});
            end
            OP_EST:
            begin
                opa = $signed({16'b0, inv_reg});
                opb = $signed({14'b0, pmid_reg});
            end
            OP_VAR:
            begin
                opa = $signed({1'b0, est_reg});
                opb = $signed({1'b0, est_reg});
            end
            OP_QLO:
            begin
                opa = 33'(cfg.quad_coeff);
                opb = $signed({13'b0, tsq_reg[19:0]});
            end
            OP_QHI:
            begin
                opa = 33'(cfg.quad_coeff);
                opb = $signed({13'b0, tsq_reg[39:20]});
            end
            OP_LIN:
            begin
                opa = 33'(cfg.lin_gain);
                opb = $signed({1'b0, est_reg});
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // Post-multiply arithmetic.
    logic [49:0]        est_sum;
    logic [36:0]        var_sum;
    logic signed [43:0] real_sum;
    logic signed [27:0] rnd;
    logic [SUMW-1:0]    trim_sum;
    logic [31:0]        k_div;
    always_comb
    begin
        est_sum  = acc_reg[49:0] + prod_reg[49:0] + 50'd32768;
        var_sum  = prod_reg[36:0] + 37'd32768;
        real_sum = 44'(acc_reg >>> 32) + 44'(prod_reg >>> 24) + 44'(cfg.cal_offset);
        rnd      = 28'((real_sum + 44'sd32768) >>> 16);
        trim_sum = sum_reg - SUMW'(max_reg) - SUMW'(min_reg);
        k_div    = (quo_reg > 32'(GAIN_ONE)) ? 32'(GAIN_ONE) : quo_reg;
    end

    // Window statistics and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            primed_reg <= 1'b0;
            est_reg    <= '0;
            var_reg    <= VAR_W'(65536);
            dcnt_reg   <= '0;
            rem_reg    <= '0;
            dvs_reg    <= '0;
            sum_reg    <= '0;
            max_reg    <= '0;
            min_reg    <= '0;
        end
        else
        begin
            if (cmd.sample_en)
            begin
                count_reg <= status.close ? '0 : count_inc[CW-1:0];
                if (count_reg == '0)
                begin
                    sum_reg <= SUMW'(sample_value);
                    max_reg <= sample_value;
                    min_reg <= sample_value;
                end
                else
                begin
                    sum_reg <= sum_reg + SUMW'(sample_value);
                    if (sample_value > max_reg)
                        max_reg <= sample_value;
                    if (sample_value < min_reg)
                        min_reg <= sample_value;
                end
            end
            case (cmd.op)
                OP_MEAN_INIT:
                begin
                    rem_reg  <= '0;
                    dvs_reg  <= DEN_W'(eff_len - CW'(2));
                    dcnt_reg <= NCW'(NW);
                end
                OP_K_INIT:
                begin
                    rem_reg  <= '0;
                    dvs_reg  <= den_reg;
                    dcnt_reg <= NCW'(NW);
                end
                OP_DIV_STEP:
                begin
                    rem_reg  <= trial_ge ? (trial - {1'b0, dvs_reg}) : trial;
                    dcnt_reg <= dcnt_reg - 1'b1;
                end
                OP_MEAN_DONE:
                begin
                    if (!primed_reg)
                    begin
                        est_reg    <= quo_reg;
                        var_reg    <= VAR_W'(65536);
                        primed_reg <= 1'b1;
                    end
                end
                OP_EST:
                    est_reg <= est_sum[47:16];
                OP_VAR:
                    var_reg <= var_sum[33:16];
                default:
                begin
                end
            endcase
        end
    end

    // Divider operands, multiplier pipeline and results (no reset needed).
    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        case (cmd.op)
            OP_MEAN_INIT:
                num_reg <= NW'({trim_sum, 16'b0});
            OP_K_INIT:
                num_reg <= NW'({pmid_reg, 16'b0});
            OP_DIV_STEP:
            begin
                num_reg <= {num_reg[NW-2:0], 1'b0};
                quo_reg <= {quo_reg[30:0], trial_ge};
            end
            OP_MEAN_DONE:
                mean_reg <= quo_reg;
            OP_PMID:
            begin
                pmid_reg <= PMID_W'(var_reg) + PMID_W'(cfg.process_noise);
                den_reg  <= DEN_W'(var_reg) + DEN_W'(cfg.process_noise)
                            + DEN_W'(cfg.measure_noise);
            end
            OP_K_DONE:
            begin
                k_reg   <= (dvs_reg == '0) ? GAIN_ONE : k_div[GAIN_W-1:0];
                inv_reg <= GAIN_ONE - ((dvs_reg == '0) ? GAIN_ONE : k_div[GAIN_W-1:0]);
            end
            OP_MUL_MK:
                acc_reg <= 68'(prod_reg);
            OP_TSQ:
                tsq_reg <= prod_reg[63:24];
            OP_QHI:
                acc_reg <= 68'(prod_reg);
            OP_LIN:
                acc_reg <= acc_reg + (68'(prod_reg) <<< 20);
            OP_CAL:
            begin
                if (rnd < 28'sd0)
                    dist_reg <= 16'd0;
                else if (rnd > 28'sd65535)
                    dist_reg <= 16'hFFFF;
                else
                    dist_reg <= rnd[15:0];
            end
            default:
            begin
            end
        endcase
    end

    assign trimmed_mean   = mean_reg;
    assign filtered_value = est_reg;
    assign distance       = dist_reg;

`ifndef SYNTHESIS
    // The window count never runs past the largest window.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WINDOW))
        else $error("window count beyond MAX_WINDOW");

    // The divider remainder stays below a nonzero divisor.
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (dvs_reg != '0) |-> (rem_reg < {1'b0, dvs_reg}))
        else $error("divider remainder not below divisor");

    // The Kalman gain and its complement always add up to one.
    a_gain_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_K_DONE) |=> (18'(k_reg) + 18'(inv_reg) == 18'(GAIN_ONE)))
        else $error("gain and complement do not sum to one");
`endif

endmodule

`default_nettype wire

// ===== src/tmkd_ctrl.sv =====
// Controller of the trimmed-mean Kalman distance filter: sequences the
// window close through the divider and multiplier steps of the datapath.
// Depends on tmkd_pkg.
`default_nettype none

module tmkd_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 out_free,
    input  wire tmkd_pkg::dp_status_t status,
    output tmkd_pkg::dp_cmd_t         cmd
);
    import tmkd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MEAN_INIT,
        S_DIV_MEAN,
        S_MEAN_DONE,
        S_PMID,
        S_K_INIT,
        S_DIV_K,
        S_K_DONE,
        S_MUL_XI,
        S_MUL_MK,
        S_EST,
        S_VAR,
        S_TSQ,
        S_QLO,
        S_QHI,
        S_LIN,
        S_CAL,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Command decode and next state.
    always_comb
    begin
        state_next    = state_reg;
        cmd.sample_en = 1'b0;
        cmd.op        = OP_NONE;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.sample_en = in_valid;
                if (in_valid && status.close)
                    state_next = S_MEAN_INIT;
            end
            S_MEAN_INIT:
            begin
                cmd.op     = OP_MEAN_INIT;
                state_next = S_DIV_MEAN;
            end
            S_DIV_MEAN:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                    state_next = S_MEAN_DONE;
            end
            S_MEAN_DONE:
            begin
                cmd.op     = OP_MEAN_DONE;
                state_next = status.primed ? S_PMID : S_IDLE;
            end
            S_PMID:
            begin
                cmd.op     = OP_PMID;
                state_next = S_K_INIT;
            end
            S_K_INIT:
            begin
                cmd.op     = OP_K_INIT;
                state_next = S_DIV_K;
            end
            S_DIV_K:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                    state_next = S_K_DONE;
            end
            S_K_DONE:
            begin
                cmd.op     = OP_K_DONE;
                state_next = S_MUL_XI;
            end
            S_MUL_XI:
            begin
                cmd.op     = OP_MUL_XI;
                state_next = S_MUL_MK;
            end
            S_MUL_MK:
            begin
                cmd.op     = OP_MUL_MK;
                state_next = S_EST;
            end
            S_EST:
            begin
                cmd.op     = OP_EST;
                state_next = S_VAR;
            end
            S_VAR:
            begin
                cmd.op     = OP_VAR;
                state_next = S_TSQ;
            end
            S_TSQ:
            begin
                cmd.op     = OP_TSQ;
                state_next = S_QLO;
            end
            S_QLO:
            begin
                cmd.op     = OP_QLO;
                state_next = S_QHI;
            end
            S_QHI:
            begin
                cmd.op     = OP_QHI;
                state_next = S_LIN;
            end
            S_LIN:
            begin
                cmd.op     = OP_LIN;
                state_next = S_CAL;
            end
            S_CAL:
            begin
                cmd.op     = OP_CAL;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    // A closing sample always starts the mean division.
    a_close_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid && status.close) |=> (state_reg == S_MEAN_INIT))
        else $error("window close did not start the division");

    // A result is loaded only when the output register can take it.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded into a full output register");

    // The divider finishes before the gain is formed.
    a_k_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_K_DONE) |-> ($past(state_reg) == S_DIV_K))
        else $error("gain formed without a finished division");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/trimmed_mean_kalman_distance_tb.sv =====
// Testbench for the trimmed-mean Kalman distance filter.
// Drives raw samples and register writes and checks every result item against
// a built-in predictor. Depends on tmkd_pkg and trimmed_mean_kalman_distance.
`timescale 1ns / 1ps

module trimmed_mean_kalman_distance_tb;
    import tmkd_pkg::*;

    localparam int MAXW = 64;
    localparam int SEQ_CYCLES = 120;

    typedef struct packed {
        logic [15:0] distance;
        logic [31:0] filtered_value;
        logic [31:0] trimmed_mean;
    } dist_result_t;

    // One row of the directed table: register write or sample, optional result.
    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [39:0] val;
        bit          has_fixed;
        logic [31:0] fixed_mean;
        logic [15:0] fixed_dist;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [39:0] cfg_data;

    // Predictor state and register copy.
    logic [6:0]         win_len_reg;
    logic [15:0]        q_reg;
    logic [15:0]        r_reg;
    logic signed [23:0] quad_reg;
    logic signed [31:0] lin_reg;
    logic signed [39:0] off_reg;
    int unsigned        cnt;
    longint unsigned    acc_sum;
    int unsigned        acc_max;
    int unsigned        acc_min;
    longint unsigned    est;
    longint unsigned    var_p;
    bit                 primed;

    dist_result_t pending_results[$];
    int           mismatches;
    int           src_idle_pct;
    int           snk_idle_pct;
    bit           hold_sink;
    int           rows_seen;

    trimmed_mean_kalman_distance #(.MAX_WINDOW(MAXW)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock, 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic longint floor_sh(longint v, int n);
        return v >>> n;
    endfunction

    // Quadratic calibration with half-up rounding and saturation.
    function automatic logic [15:0] calibrate_distance(longint unsigned t);
        longint unsigned tsq;
        longint          quad;
        longint          lin;
        longint          total;
        longint          r;
        tsq   = (t * t) >> 24;
        quad  = longint'(quad_reg) * longint'(tsq);
        lin   = longint'(lin_reg) * longint'(t);
        total = floor_sh(quad, 32) + floor_sh(lin, 24) + longint'(off_reg);
        r     = floor_sh(total + 32768, 16);
        if (r < 0)
            return 16'd0;
        if (r > 65535)
            return 16'hFFFF;
        return r[15:0];
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [39:0] val);
        case (idx)
            REG_WINDOW_LENGTH: win_len_reg = val[6:0];
            REG_PROCESS_NOISE: q_reg = val[15:0];
            REG_MEASURE_NOISE: r_reg = val[15:0];
            REG_QUAD_COEFF:    quad_reg = val[23:0];
            REG_LIN_GAIN:      lin_reg = val[31:0];
            REG_CAL_OFFSET:    off_reg = val;
            default: ;
        endcase
    endfunction

    // Advance the window and filter by one sample; returns 1 with a result.
    function automatic bit predict_sample(logic [15:0] s, output dist_result_t res);
        int unsigned     len;
        longint unsigned mean;
        longint unsigned pmid;
        longint unsigned den;
        longint unsigned k;
        longint unsigned inv;
        res = '0;
        len = win_len_reg;
        if (len < 3)
            len = 3;
        if (len > MAXW)
            len = MAXW;
        if (cnt == 0)
        begin
            acc_sum = 0;
            acc_max = s;
            acc_min = s;
        end
        acc_sum += s;
        if (s > acc_max)
            acc_max = s;
        if (s < acc_min)
            acc_min = s;
        cnt++;
        if (cnt < len)
            return 0;
        mean = ((acc_sum - acc_max - acc_min) << 16) / (len - 2);
        mean &= 64'hFFFF_FFFF;
        cnt = 0;
        acc_sum = 0;
        if (!primed)
        begin
            est = mean;
            var_p = 65536;
            primed = 1;
            return 0;
        end
        pmid = var_p + q_reg;
        den = pmid + r_reg;
        k = (den == 0) ? 65536 : (pmid << 16) / den;
        if (k > 65536)
            k = 65536;
        inv = 65536 - k;
        est = ((est * inv + mean * k + 32768) >> 16) & 64'hFFFF_FFFF;
        var_p = ((inv * pmid + 32768) >> 16) & 64'h3FFFF;
        res.trimmed_mean = mean[31:0];
        res.filtered_value = est[31:0];
        res.distance = calibrate_distance(est);
        return 1;
    endfunction

    // One register write, with the channel left quiet afterwards.
    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
        @(posedge clk);
    endtask

    // Offer one sample, with random idle cycles before it. The valid flag is
    // left up after acceptance; the next idle cycle or drain() drops it.
    task automatic send_sample(logic [15:0] s, bit has_fixed, logic [31:0] fm,
                               logic [15:0] fd);
        dist_result_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (predict_sample(s, res))
        begin
            if (has_fixed && (res.trimmed_mean != fm || res.distance != fd))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Directed row %0d: predictor gives mean %h dist %h, table %h %h",
                             rows_seen, res.trimmed_mean, res.distance, fm, fd);
            end
            pending_results.push_back(res);
        end
    endtask

    // Stop offering samples, wait until all results are in, then let a
    // closing sequence finish.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SEQ_CYCLES)
            @(posedge clk);
    endtask

    // Sink: random stalls, one long hold-off, result checking.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected distance item %h", m_axis_tdata);
                end
                else
                begin
                    dist_result_t exp_res;
                    exp_res = pending_results.pop_front();
                    if (m_axis_tdata != exp_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: exp mean %h filt %h dist %h, got %h %h %h",
                                     exp_res.trimmed_mean, exp_res.filtered_value,
                                     exp_res.distance, m_axis_tdata[31:0],
                                     m_axis_tdata[63:32], m_axis_tdata[79:64]);
                    end
                end
            end
            m_axis_tready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic random_window_run(int n_items);
        int i;
        logic [15:0] base;
        base = 16'($urandom);
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(9) < 7)
                send_sample(16'(base + 16'($urandom_range(400)) - 16'd200), 0, '0, '0);
            else
                send_sample(16'($urandom), 0, '0, '0);
        end
    endtask

    stim_row_t table_rows[$];

    initial
    begin
        stim_row_t row;
        int i;
        int ph;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_sink = 0;
        mismatches = 0;
        src_idle_pct = 29;
        snk_idle_pct = 46;
        win_len_reg = 50;
        q_reg = 590;
        r_reg = 11796;
        quad_reg = 0;
        lin_reg = 3291814;
        off_reg = -40'sd159140916;
        cnt = 0;
        acc_sum = 0;
        acc_max = 0;
        acc_min = 0;
        est = 0;
        var_p = 65536;
        primed = 0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: window length below range acts as 3.
        table_rows.push_back('{1, REG_WINDOW_LENGTH, 40'd0, 0, 0, 0});
        table_rows.push_back('{1, REG_CAL_OFFSET, 40'd0, 0, 0, 0});
        table_rows.push_back('{1, REG_LIN_GAIN, 40'd0, 0, 0, 0});
        // First window only seeds the filter.
        table_rows.push_back('{0, 0, 40'd0, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'hFFFF, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'd5, 0, 0, 0});
        // Extremes; calibration zero gives distance zero.
        table_rows.push_back('{0, 0, 40'hFFFF, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'hFFFF, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'hFFFF, 1, 32'hFFFF_0000, 16'd0});
        // Huge offset saturates high, zero noise gives gain one.
        table_rows.push_back('{1, REG_CAL_OFFSET, 40'h7F_FFFF_FFFF, 0, 0, 0});
        table_rows.push_back('{1, REG_PROCESS_NOISE, 40'd0, 0, 0, 0});
        table_rows.push_back('{1, REG_MEASURE_NOISE, 40'd0, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'd0, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'd0, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'd0, 1, 32'd0, 16'hFFFF});
        // Negative offset saturates low; mid-window shrink of the length.
        table_rows.push_back('{1, REG_CAL_OFFSET, 40'h80_0000_0000, 0, 0, 0});
        table_rows.push_back('{1, REG_QUAD_COEFF, 40'h7F_FFFF, 0, 0, 0});
        table_rows.push_back('{1, REG_WINDOW_LENGTH, 40'd127, 0, 0, 0});
        for (i = 0; i < 5; i++)
            table_rows.push_back('{0, 0, 40'(i * 1000), 0, 0, 0});
        table_rows.push_back('{1, REG_WINDOW_LENGTH, 40'd3, 0, 0, 0});
        table_rows.push_back('{0, 0, 40'd7, 0, 0, 0});

        foreach (table_rows[j])
        begin
            row = table_rows[j];
            rows_seen = j;
            if (row.is_cfg)
            begin
                drain();
                write_reg(row.idx, row.val);
            end
            else
                send_sample(row.val[15:0], row.has_fixed, row.fixed_mean,
                            row.fixed_dist);
        end
        drain();

        // Random phases with different settings and idle patterns.
        for (ph = 0; ph < 9; ph++)
        begin
            case (ph / 3)
                0: begin src_idle_pct = 29; snk_idle_pct = 46; end
                1: begin src_idle_pct = 46; snk_idle_pct = 29; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            drain();
            write_reg(REG_WINDOW_LENGTH, (ph == 4) ? 40'd64 : 40'($urandom_range(3, 12)));
            write_reg(REG_PROCESS_NOISE, (ph == 1) ? 40'hFFFF : 40'($urandom_range(65535)));
            write_reg(REG_MEASURE_NOISE, (ph == 2) ? 40'hFFFF :
                      40'($urandom_range(1, 65535)));
            write_reg(REG_QUAD_COEFF, (ph == 3) ? 40'h80_0000 : 40'($urandom_range(4095)));
            write_reg(REG_LIN_GAIN, (ph == 5) ? 40'h8000_0000 :
                      ((ph == 6) ? 40'h7FFF_FFFF : 40'($urandom_range(1 << 24, 1 << 25))));
            write_reg(REG_CAL_OFFSET, {{8{1'b1}}, 32'($urandom)});
            // Long receiver hold-off while samples keep arriving.
            if (ph == 7)
                hold_sink = 1;
            random_window_run(104);
        end
        hold_sink = 0;
        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Release the long hold-off after a counted stretch of cycles.
    initial
    begin
        int held;
        held = 0;
        wait (hold_sink);
        while (held < 3000)
        begin
            @(posedge clk);
            held++;
        end
        hold_sink = 0;
    end

    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
